### sv/spq_pkg.sv
// Shared definitions for the sorted priority queue.
// Holds the default sizes, output field widths, operation codes and the cell control type.
// No dependencies.
package spq_pkg;

  localparam int CAPACITY_DEF      = 16;
  localparam int ITEM_BITS_DEF     = 32;
  localparam int PRIORITY_BITS_DEF = 8;

  localparam int OUT_ITEM_BITS  = 32;
  localparam int OUT_COUNT_BITS = 5;
  localparam int OUT_TDATA_BITS = 40;
  localparam int OUT_TUSER_BITS = 2;

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_DEQUEUE = 1'b1
  } spq_op_t;

  typedef struct packed {
    logic enq;
    logic deq;
  } spq_ctrl_t;

endpackage

### sv/spq_cell.sv
// One storage cell of the sorted priority queue chain.
// Holds one item, its priority and a valid bit; shifts toward either neighbor.
// Depends on spq_pkg.
module spq_cell #(
  parameter int ITEM_BITS     = spq_pkg::ITEM_BITS_DEF,
  parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  spq_pkg::spq_ctrl_t       ctrl,
  input  logic [ITEM_BITS-1:0]     new_item,
  input  logic [PRIORITY_BITS-1:0] new_prio,
  input  logic [ITEM_BITS-1:0]     left_item,
  input  logic [PRIORITY_BITS-1:0] left_prio,
  input  logic                     left_valid,
  input  logic                     left_ins,
  input  logic [ITEM_BITS-1:0]     right_item,
  input  logic [PRIORITY_BITS-1:0] right_prio,
  input  logic                     right_valid,
  output logic [ITEM_BITS-1:0]     item,
  output logic [PRIORITY_BITS-1:0] prio,
  output logic                     valid,
  output logic                     ins
);
  import spq_pkg::*;

  // A cell lies at or after the insertion point when it is empty or holds a larger priority.
  assign ins = !valid || (prio > new_prio);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.deq) begin
      valid <= right_valid;
    end else if (ctrl.enq) begin
      if (left_ins) begin
        valid <= left_valid;
      end else if (ins) begin
        valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.deq) begin
      item <= right_item;
      prio <= right_prio;
    end else if (ctrl.enq) begin
      if (left_ins) begin
        item <= left_item;
        prio <= left_prio;
      end else if (ins) begin
        item <= new_item;
        prio <= new_prio;
      end
    end
  end

endmodule

### sv/sorted_priority_queue_core.sv
// Top level of the sorted priority queue: a chain of spq_cell instances and the result register.
// Depends on spq_pkg and spq_cell.
//
// The queue is a row of CAPACITY cells kept sorted by ascending priority, the head in cell zero.
// Every cell compares its priority with the incoming one at the same time, so an enqueue or a
// dequeue updates the whole row at once; a new transfer can be accepted every cycle unless the
// output stalls. Each accepted transfer produces exactly one result, which sits in an output
// register and appears on the cycle after the input transfer; the input is stalled only while
// that register holds a result the downstream side has not taken. Storage comes out of reset
// empty with no clearing pass. An enqueue into a full queue is dropped and flagged as rejected.
module sorted_priority_queue_core #(
  parameter int CAPACITY      = spq_pkg::CAPACITY_DEF,
  parameter int ITEM_BITS     = spq_pkg::ITEM_BITS_DEF,
  parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF
) (
  input  logic                                               clk,
  input  logic                                               rst,
  input  logic                                               s_tvalid,
  output logic                                               s_tready,
  // Fields from bit 0: item_value, priority_req, zero fill to whole bytes.
  input  logic [((ITEM_BITS+PRIORITY_BITS+7)/8)*8-1:0]       s_tdata,
  // Fields from bit 0: operation.
  input  logic                                               s_tuser,
  output logic                                               m_tvalid,
  input  logic                                               m_tready,
  // Fields from bit 0: item_out, queue_count, zero fill to whole bytes.
  output logic [spq_pkg::OUT_TDATA_BITS-1:0]                 m_tdata,
  // Fields from bit 0: item_valid, rejected.
  output logic [spq_pkg::OUT_TUSER_BITS-1:0]                 m_tuser
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [ITEM_BITS-1:0]     cell_item  [CAPACITY];
  logic [PRIORITY_BITS-1:0] cell_prio  [CAPACITY];
  logic [CAPACITY-1:0]      cell_valid;
  logic [CAPACITY-1:0]      cell_ins;
  logic [CAPACITY-1:0]      order_err;

  logic [ITEM_BITS-1:0]     new_item;
  logic [PRIORITY_BITS-1:0] new_prio;
  spq_op_t                  op;
  logic                     in_fire;
  logic                     full;
  logic                     empty;
  spq_ctrl_t                ctrl;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;

  logic [ITEM_BITS+OUT_ITEM_BITS-1:0] item_ext;
  logic [CNT_W+OUT_COUNT_BITS-1:0]    count_ext;
  logic [OUT_ITEM_BITS-1:0]           item_out_next;

  assign new_item = s_tdata[ITEM_BITS-1:0];
  assign new_prio = s_tdata[ITEM_BITS +: PRIORITY_BITS];
  assign op       = spq_op_t'(s_tuser);

  assign s_tready = !m_tvalid || m_tready;
  assign in_fire  = s_tvalid && s_tready;
  assign full     = (count == CNT_W'(CAPACITY));
  assign empty    = (count == '0);

  assign ctrl.enq = in_fire && (op == OP_ENQUEUE) && !full;
  assign ctrl.deq = in_fire && (op == OP_DEQUEUE);

  always_comb begin
    count_next = count;
    if (ctrl.enq) begin
      count_next = count + CNT_W'(1);
    end else if (ctrl.deq && !empty) begin
      count_next = count - CNT_W'(1);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ITEM_BITS-1:0]     l_item;
    logic [PRIORITY_BITS-1:0] l_prio;
    logic                     l_valid;
    logic                     l_ins;
    logic [ITEM_BITS-1:0]     r_item;
    logic [PRIORITY_BITS-1:0] r_prio;
    logic                     r_valid;

    if (i == 0) begin : g_head
      assign l_item  = '0;
      assign l_prio  = '0;
      assign l_valid = 1'b0;
      assign l_ins   = 1'b0;
      assign order_err[i] = 1'b0;
    end else begin : g_body
      assign l_item  = cell_item[i-1];
      assign l_prio  = cell_prio[i-1];
      assign l_valid = cell_valid[i-1];
      assign l_ins   = cell_ins[i-1];
      assign order_err[i] = cell_valid[i] && (cell_prio[i-1] > cell_prio[i]);
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign r_item  = '0;
      assign r_prio  = '0;
      assign r_valid = 1'b0;
    end else begin : g_inner
      assign r_item  = cell_item[i+1];
      assign r_prio  = cell_prio[i+1];
      assign r_valid = cell_valid[i+1];
    end

    spq_cell #(
      .ITEM_BITS     (ITEM_BITS),
      .PRIORITY_BITS (PRIORITY_BITS)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .new_item    (new_item),
      .new_prio    (new_prio),
      .left_item   (l_item),
      .left_prio   (l_prio),
      .left_valid  (l_valid),
      .left_ins    (l_ins),
      .right_item  (r_item),
      .right_prio  (r_prio),
      .right_valid (r_valid),
      .item        (cell_item[i]),
      .prio        (cell_prio[i]),
      .valid       (cell_valid[i]),
      .ins         (cell_ins[i])
    );
  end

  assign item_ext  = {{OUT_ITEM_BITS{1'b0}}, cell_item[0]};
  assign count_ext = {{OUT_COUNT_BITS{1'b0}}, count_next};
  assign item_out_next = (ctrl.deq && !empty) ? item_ext[OUT_ITEM_BITS-1:0] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      if (in_fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      m_tdata <= {{(OUT_TDATA_BITS - OUT_ITEM_BITS - OUT_COUNT_BITS){1'b0}},
                  count_ext[OUT_COUNT_BITS-1:0], item_out_next};
      m_tuser <= {(op == OP_ENQUEUE) && full, ctrl.deq && !empty};
    end
  end

`ifndef SYNTHESIS
  a_valid_prefix: assert property (@(posedge clk) disable iff (rst)
    (cell_valid & (cell_valid + CAPACITY'(1))) == '0)
    else $error("occupied cells are not a contiguous run from the head");

  a_count_match: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == int'(count))
    else $error("entry count disagrees with occupied cells");

  a_sorted: assert property (@(posedge clk) disable iff (rst)
    order_err == '0)
    else $error("stored priorities are out of order");

  a_reject: assert property (@(posedge clk) disable iff (rst)
    in_fire && (op == OP_ENQUEUE) && full |=> m_tvalid && m_tuser[1] && $stable(count))
    else $error("enqueue into a full queue was not rejected");

  a_dequeue: assert property (@(posedge clk) disable iff (rst)
    in_fire && (op == OP_DEQUEUE) && !empty |=> m_tvalid && m_tuser[0]
      && (count == $past(count) - CNT_W'(1)))
    else $error("dequeue from a non-empty queue returned no entry");
`endif

endmodule

### verif/sorted_priority_queue_core_test.sv
// Testbench for sorted_priority_queue_core: random enqueue and dequeue traffic with bursty input,
// stalling output, and a predictor that keeps its own sorted copy of the queue to check each result.
// Depends on spq_pkg and the sorted_priority_queue_core RTL.
module sorted_priority_queue_core_test;
  import spq_pkg::*;

  localparam int CAP       = CAPACITY_DEF;
  localparam int S_BITS    = ((ITEM_BITS_DEF + PRIORITY_BITS_DEF + 7) / 8) * 8;
  localparam int IDLE_LIMIT = 2000;
  localparam int LONG_HOLD  = 300;

  typedef struct packed {
    spq_op_t                      op;
    logic [ITEM_BITS_DEF-1:0]     value;
    logic [PRIORITY_BITS_DEF-1:0] prio;
    logic                         drain_first;
  } queue_req_t;

  typedef struct packed {
    logic [OUT_ITEM_BITS-1:0]  item;
    logic                      hit;
    logic [OUT_COUNT_BITS-1:0] count;
    logic                      rej;
  } queue_res_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [S_BITS-1:0]                s_tdata = '0;
  logic                             s_tuser = 1'b0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0]        m_tdata;
  logic [OUT_TUSER_BITS-1:0]        m_tuser;

  queue_req_t pending_reqs[$];
  queue_res_t expected_results[$];
  queue_req_t cur_req;

  logic [ITEM_BITS_DEF-1:0]     held_item [0:CAP-1];
  logic [PRIORITY_BITS_DEF-1:0] held_prio [0:CAP-1];
  int held_n = 0;

  int n_acc = 0;
  int n_res = 0;
  int mismatches = 0;
  int n_enq_ok = 0;
  int n_rejected = 0;
  int n_deq_hit = 0;
  int n_deq_empty = 0;
  int peak_depth = 0;

  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  bit long_hold_done = 1'b0;
  int mode_left = 0;
  int rx_mode = 0;
  logic [7:0] stall_mask = 8'hff;
  logic [2:0] rx_phase = '0;
  int idle_cycles = 0;

  sorted_priority_queue_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic queue_res_t predict_queue_result(queue_req_t req);
    queue_res_t r;
    int pos;
    int i;
    r = '0;
    if (req.op == OP_ENQUEUE) begin
      if (held_n >= CAP) begin
        r.rej = 1'b1;
        n_rejected++;
      end else begin
        pos = held_n;
        for (i = held_n - 1; i >= 0; i--) begin
          if (held_prio[i] > req.prio) pos = i;
        end
        for (i = held_n; i > pos; i--) begin
          held_item[i] = held_item[i-1];
          held_prio[i] = held_prio[i-1];
        end
        held_item[pos] = req.value;
        held_prio[pos] = req.prio;
        held_n++;
        n_enq_ok++;
        if (held_n > peak_depth) peak_depth = held_n;
      end
    end else begin
      if (held_n > 0) begin
        r.item = held_item[0];
        r.hit = 1'b1;
        for (i = 1; i < held_n; i++) begin
          held_item[i-1] = held_item[i];
          held_prio[i-1] = held_prio[i];
        end
        held_n--;
        n_deq_hit++;
      end else begin
        n_deq_empty++;
      end
    end
    r.count = held_n[OUT_COUNT_BITS-1:0];
    return r;
  endfunction

  task automatic add_req(spq_op_t op, logic [ITEM_BITS_DEF-1:0] value,
                         logic [PRIORITY_BITS_DEF-1:0] prio, logic drain_first);
    queue_req_t req;
    req.op = op;
    req.value = value;
    req.prio = prio;
    req.drain_first = drain_first;
    pending_reqs.push_back(req);
  endtask

  // Driver: presents the next pending item whenever the slot is free, in bursts.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(predict_queue_result(cur_req));
        n_acc <= n_acc + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          s_tvalid <= 1'b0;
        end else if (pending_reqs.size() == 0) begin
          s_tvalid <= 1'b0;
        end else if (pending_reqs[0].drain_first && (s_tvalid || n_acc != n_res)) begin
          s_tvalid <= 1'b0;
        end else begin
          cur_req = pending_reqs.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= cur_req.op;
          s_tdata <= {cur_req.prio, cur_req.value};
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 16);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // Receiver: stall pattern changes every so often, with one long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else if (!long_hold_done && n_res >= 400) begin
      long_hold_done <= 1'b1;
      hold_left <= LONG_HOLD;
      m_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode <= $urandom_range(0, 3);
        mode_left <= $urandom_range(20, 120);
        stall_mask <= 8'($urandom);
      end else begin
        mode_left <= mode_left - 1;
      end
      rx_phase <= rx_phase + 1'b1;
      case (rx_mode)
        0: begin
          m_tready <= 1'b1;
        end
        1: begin
          m_tready <= ($urandom_range(0, 1) == 1);
        end
        2: begin
          m_tready <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          m_tready <= stall_mask[rx_phase];
        end
      endcase
    end
  end

  // Monitor: every result transfer is checked against the oldest expectation.
  always @(posedge clk) begin
    queue_res_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual tdata %h tuser %b",
                 $time, m_tdata, m_tuser);
        mismatches <= mismatches + 1;
      end else begin
        exp_r = expected_results.pop_front();
        n_res <= n_res + 1;
        if (m_tdata[OUT_ITEM_BITS-1:0] !== exp_r.item ||
            m_tdata[OUT_ITEM_BITS +: OUT_COUNT_BITS] !== exp_r.count ||
            m_tuser[0] !== exp_r.hit || m_tuser[1] !== exp_r.rej) begin
          $display("%0t: result mismatch, expected item %h count %0d valid %b rejected %b",
                   $time, exp_r.item, exp_r.count, exp_r.hit, exp_r.rej);
          $display("%0t:                  actual item %h count %0d valid %b rejected %b",
                   $time, m_tdata[OUT_ITEM_BITS-1:0], m_tdata[OUT_ITEM_BITS +: OUT_COUNT_BITS],
                   m_tuser[0], m_tuser[1]);
          mismatches <= mismatches + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("sorted_priority_queue_core regression: fail");
        $finish;
      end
    end
  end

  initial begin
    int i;
    int seg_left;
    int op_mode;
    int prio_mode;
    int base;
    logic [PRIORITY_BITS_DEF-1:0] p;
    spq_op_t op;

    // Directed: empty dequeue, extremes, ties, a full queue with a rejected enqueue.
    add_req(OP_DEQUEUE, 32'hffff_ffff, 8'hff, 1'b0);
    add_req(OP_ENQUEUE, 32'hffff_ffff, 8'hff, 1'b0);
    add_req(OP_ENQUEUE, 32'h0000_0000, 8'h00, 1'b0);
    add_req(OP_ENQUEUE, 32'h0000_0a01, 8'h80, 1'b0);
    add_req(OP_ENQUEUE, 32'h0000_0a02, 8'h80, 1'b0);
    add_req(OP_ENQUEUE, 32'h0000_0a03, 8'h80, 1'b0);
    add_req(OP_ENQUEUE, 32'h5555_5555, 8'h55, 1'b0);
    add_req(OP_ENQUEUE, 32'haaaa_aaaa, 8'haa, 1'b0);
    add_req(OP_ENQUEUE, 32'h0000_0b01, 8'h00, 1'b0);
    add_req(OP_ENQUEUE, 32'h0000_0c01, 8'hff, 1'b0);
    for (i = 0; i < 7; i++) add_req(OP_ENQUEUE, $urandom, 8'($urandom_range(0, 255)), 1'b0);
    add_req(OP_ENQUEUE, 32'hdead_0001, 8'h01, 1'b0);
    for (i = 0; i < 6; i++) add_req(OP_DEQUEUE, $urandom, 8'($urandom_range(0, 255)), 1'b0);

    seg_left = 0;
    op_mode = 0;
    prio_mode = 0;
    base = 0;
    for (i = 0; i < 1925; i++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 80);
        op_mode = $urandom_range(0, 2);
        prio_mode = $urandom_range(0, 3);
        base = $urandom_range(0, 250);
      end
      seg_left--;
      case (op_mode)
        0: op = ($urandom_range(0, 99) < 75) ? OP_ENQUEUE : OP_DEQUEUE;
        1: op = ($urandom_range(0, 99) < 75) ? OP_DEQUEUE : OP_ENQUEUE;
        default: op = ($urandom_range(0, 1) == 0) ? OP_ENQUEUE : OP_DEQUEUE;
      endcase
      case (prio_mode)
        0: p = 8'($urandom_range(0, 255));
        1: p = 8'($urandom_range(0, 3));
        2: p = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hff;
        default: p = 8'(base + int'($urandom_range(0, 5)));
      endcase
      add_req(op, $urandom, p, (i == 0 || i == 700 || i == 1400));
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || s_tvalid || n_res != n_acc) @(negedge clk);
    repeat (8) @(negedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d results never arrived, expected item %h, actual none",
               $time, expected_results.size(), expected_results[0].item);
      mismatches++;
    end
    $display("Covered %0d transfers: %0d enqueues stored, %0d rejected on a full queue,",
             n_acc, n_enq_ok, n_rejected);
    $display("%0d dequeues returned an entry, %0d found it empty; deepest fill %0d of %0d.",
             n_deq_hit, n_deq_empty, peak_depth, CAP);
    if (mismatches == 0) begin
      $display("sorted_priority_queue_core regression: pass");
    end else begin
      $display("sorted_priority_queue_core regression: fail");
    end
    $finish;
  end

endmodule

### files.f
sv/spq_pkg.sv
sv/spq_cell.sv
sv/sorted_priority_queue_core.sv
verif/sorted_priority_queue_core_test.sv
